[rtl/ssr_pkg.sv]
// Shared types, constants and helpers for the stream substring replace block.
// Used by the channel interfaces and by every module of the block.
package ssr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int PAT_IDX_W   = $clog2(PATTERN_MAX);
    localparam int REP_IDX_W   = $clog2(REPLACE_MAX);
    localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
    localparam int REP_N_W     = $clog2(REPLACE_MAX + 1);
    localparam int CNT_W       = (PAT_IDX_W > REP_IDX_W) ? PAT_IDX_W : REP_IDX_W;
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] UPPER_A      = 8'd65;
    localparam logic [7:0] UPPER_Z      = 8'd90;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_ALL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_UPPER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OCCURRENCE  = 3'd6;

    typedef logic [PATTERN_MAX-1:0][7:0] t_pat_bytes;
    typedef logic [REPLACE_MAX-1:0][7:0] t_rep_bytes;

    typedef struct packed {
        t_pat_bytes pattern;
        logic [3:0] pat_len;
        t_rep_bytes replacement;
        logic [3:0] rep_len;
        logic       replace_all;
        logic       fold_upper;
        logic [3:0] occurrence;
    } t_cfg;

    // One request for the back end: an optional separator, an optional
    // replacement, then a run of copied bytes; eot marks the end of text.
    typedef struct packed {
        logic               nl;
        logic [REP_N_W-1:0] rep_n;
        logic [FILL_W-1:0]  data_n;
        t_pat_bytes         data;
        logic               eot;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NL,
        PH_REP,
        PH_DATA,
        PH_MARK
    } t_phase;

    function automatic logic [7:0] fold_case(input logic [7:0] c, input logic icase);
        logic [7:0] r;
        r = c;
        if (icase && c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

[rtl/ssr_in_if.sv]
// Input channel of the substring replace block: one text byte per request.
// Depends on ssr_pkg.
interface ssr_in_if;
    import ssr_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

[rtl/ssr_out_if.sv]
// Output channel of the substring replace block: one produced byte per request.
// Depends on ssr_pkg.
interface ssr_out_if;
    import ssr_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_done;

    modport source (output valid, output out_byte, output byte_valid,
                    output run_last, output text_done, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input run_last, input text_done, output ready);
endinterface

[rtl/ssr_front.sv]
// Front end: accepts text bytes, keeps the lookahead window and line state,
// and turns each byte into at most one back-end request. Depends on ssr_pkg, ssr_in_if.
module ssr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssr_pkg::t_cfg i_cfg,
    ssr_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output ssr_pkg::t_cmd o_cmd
);
    import ssr_pkg::*;

    t_pat_bytes        r_win;
    logic [FILL_W-1:0] r_fill;
    logic [3:0]        r_occ_cnt;
    logic              r_finished;
    logic              r_line_open;
    logic              r_emitted;

    logic               accept;
    logic               is_nl;
    logic               ending;
    logic [FILL_W-1:0]  plen;
    logic [REP_N_W-1:0] rlen;
    t_pat_bytes         nw;
    t_pat_bytes         aw;
    logic [FILL_W-1:0]  nfill;
    logic [FILL_W-1:0]  afill;
    logic [FILL_W-1:0]  sh;
    logic               mism;
    logic [3:0]         cnt_inc;
    logic [3:0]         n_occ_cnt;
    logic               n_finished;
    logic               do_rep;
    logic               do_copy;
    logic               nl_out;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        is_nl  = (i_in.in_byte == NEWLINE_BYTE);
        ending = is_nl || i_in.end_of_text;

        if (i_cfg.pat_len == 4'd0) begin
            plen = FILL_W'(1);
        end else if (i_cfg.pat_len > 4'(PATTERN_MAX)) begin
            plen = FILL_W'(PATTERN_MAX);
        end else begin
            plen = FILL_W'(i_cfg.pat_len);
        end
        if (i_cfg.rep_len > 4'(REPLACE_MAX)) begin
            rlen = REP_N_W'(REPLACE_MAX);
        end else begin
            rlen = REP_N_W'(i_cfg.rep_len);
        end

        nw    = r_win;
        nfill = r_fill;
        if (!is_nl && r_fill < FILL_W'(PATTERN_MAX)) begin
            nw[r_fill[PAT_IDX_W-1:0]] = i_in.in_byte;
            nfill = r_fill + 1'b1;
        end

        mism = 1'b0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if (FILL_W'(k) < plen &&
                fold_case(nw[k], i_cfg.fold_upper) !=
                fold_case(i_cfg.pattern[k], i_cfg.fold_upper)) begin
                mism = 1'b1;
            end
        end

        cnt_inc    = (r_occ_cnt == 4'd15) ? r_occ_cnt : r_occ_cnt + 4'd1;
        n_occ_cnt  = r_occ_cnt;
        n_finished = r_finished;
        do_rep     = 1'b0;
        do_copy    = 1'b0;
        if (!is_nl && nfill >= plen) begin
            if (!r_finished && !mism) begin
                n_occ_cnt = cnt_inc;
                if (i_cfg.occurrence == 4'd0 || cnt_inc == i_cfg.occurrence ||
                    i_cfg.replace_all) begin
                    do_rep = 1'b1;
                    if (!i_cfg.replace_all && i_cfg.occurrence == 4'd0) begin
                        n_finished = 1'b1;
                    end
                    if (i_cfg.occurrence != 4'd0 && cnt_inc == i_cfg.occurrence) begin
                        n_finished = 1'b1;
                    end
                end
            end
            do_copy = !do_rep;
        end

        if (do_rep) begin
            sh = plen;
        end else if (do_copy) begin
            sh = FILL_W'(1);
        end else begin
            sh = '0;
        end
        aw    = nw >> {sh, 3'b000};
        afill = (sh >= nfill) ? '0 : nfill - sh;

        // A separator goes out ahead of the first byte of every later line.
        nl_out = !is_nl && !r_line_open && r_emitted;

        o_cmd.nl    = nl_out;
        o_cmd.rep_n = do_rep ? rlen : '0;
        o_cmd.eot   = i_in.end_of_text;
        if (do_copy) begin
            // The copied head byte and any flushed remainder are one run.
            o_cmd.data   = nw;
            o_cmd.data_n = ending ? nfill : FILL_W'(1);
        end else begin
            o_cmd.data   = aw;
            o_cmd.data_n = ending ? afill : '0;
        end

        o_push = accept && (o_cmd.nl || o_cmd.rep_n != '0 || o_cmd.data_n != '0 ||
                            o_cmd.eot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_occ_cnt   <= '0;
            r_finished  <= 1'b0;
            r_line_open <= 1'b0;
            r_emitted   <= 1'b0;
        end else if (accept) begin
            if (ending) begin
                r_fill      <= '0;
                r_occ_cnt   <= '0;
                r_finished  <= 1'b0;
                r_line_open <= 1'b0;
            end else begin
                r_fill      <= afill;
                r_occ_cnt   <= n_occ_cnt;
                r_finished  <= n_finished;
                r_line_open <= 1'b1;
            end
            if (i_in.end_of_text) begin
                r_emitted <= 1'b0;
            end else if (!is_nl) begin
                r_emitted <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= aw;
        end
    end

endmodule

[rtl/ssr_cmd_fifo.sv]
// Short request queue between the front and back ends of the block.
// Depends on ssr_pkg.
module ssr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssr_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ssr_pkg::t_cmd o_data
);
    import ssr_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/ssr_back.sv]
// Back end: expands queued requests into output bytes, one per cycle unless the
// output stalls, into a registered output stage. Depends on ssr_pkg, ssr_out_if.
module ssr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssr_pkg::t_rep_bytes i_rep_bytes,
    input  logic                i_q_valid,
    input  ssr_pkg::t_cmd       i_q_data,
    output logic                o_q_pop,
    ssr_out_if.source           o_out
);
    import ssr_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_obvalid;
    logic             r_olast;
    logic             r_odone;

    t_phase     after;
    logic [7:0] cur_byte;
    logic       cur_bvalid;
    logic       last;
    logic       emit;
    logic [3:0] cnt_next;

    function automatic t_phase first_phase(input t_cmd c);
        t_phase p;
        if (c.nl) begin
            p = PH_NL;
        end else if (c.rep_n != '0) begin
            p = PH_REP;
        end else if (c.data_n != '0) begin
            p = PH_DATA;
        end else begin
            p = PH_MARK;
        end
        return p;
    endfunction

    assign cnt_next = 4'({1'b0, r_cnt}) + 4'd1;

    // Byte of the current phase and the phase that follows it.
    always_comb begin
        cur_byte   = 8'd0;
        cur_bvalid = 1'b1;
        after      = PH_IDLE;
        case (r_phase)
            PH_NL: begin
                cur_byte = NEWLINE_BYTE;
                if (r_cmd.rep_n != '0) begin
                    after = PH_REP;
                end else if (r_cmd.data_n != '0) begin
                    after = PH_DATA;
                end
            end
            PH_REP: begin
                cur_byte = i_rep_bytes[r_cnt[REP_IDX_W-1:0]];
                if (cnt_next != 4'(r_cmd.rep_n)) begin
                    after = PH_REP;
                end else if (r_cmd.data_n != '0) begin
                    after = PH_DATA;
                end
            end
            PH_DATA: begin
                cur_byte = r_cmd.data[r_cnt[PAT_IDX_W-1:0]];
                if (cnt_next != 4'(r_cmd.data_n)) begin
                    after = PH_DATA;
                end
            end
            PH_MARK: begin
                cur_bvalid = 1'b0;
            end
            default: begin
                cur_bvalid = 1'b0;
            end
        endcase
        last = (after == PH_IDLE);
    end

    // Next phase: a finished request hands over to the queue head at once.
    always_comb begin
        emit    = (r_phase != PH_IDLE) && (!r_ovalid || o_out.ready);
        o_q_pop = i_q_valid && ((r_phase == PH_IDLE) || (emit && last));
        if (o_q_pop) begin
            n_phase = first_phase(i_q_data);
            n_cnt   = '0;
        end else if (emit) begin
            n_phase = after;
            n_cnt   = (after != r_phase) ? '0 : r_cnt + 1'b1;
        end else begin
            n_phase = r_phase;
            n_cnt   = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
        if (emit) begin
            r_obyte   <= cur_byte;
            r_obvalid <= cur_bvalid;
            r_olast   <= last;
            r_odone   <= last && r_cmd.eot;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_byte   = r_obyte;
    assign o_out.byte_valid = r_obvalid;
    assign o_out.run_last   = r_olast;
    assign o_out.text_done  = r_odone;

endmodule

[rtl/stream_substring_replace.sv]
// Top level of the stream substring replace block: configuration registers,
// front end, request queue and back end. Depends on ssr_pkg and both interfaces.
//
// Text enters one byte per request and is rewritten line by line like a sed
// substitute of a fixed string: the front end accepts one byte per cycle while
// its four-entry request queue has room, and the back end sends one output
// byte per cycle while the receiver is ready, so plain copying runs at one
// byte per cycle when neither side stalls; a byte that expands (a separator,
// a replacement of up to eight bytes, or the flush of up to eight held bytes
// at a line end) yields its bytes in turn, and input stalls once the queue
// fills. Empty lines are dropped, a newline precedes every later line, and an
// end of text that yields no data gives one bare end marker. The user must
// write configuration only while the block is idle; the block does not check.
module stream_substring_replace (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ssr_in_if.sink                           i_in,
    ssr_out_if.source                        o_out
);
    import ssr_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd q_head;
    logic front_push;
    logic q_full;
    logic q_valid;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern     <= '0;
            r_cfg.pat_len     <= 4'd1;
            r_cfg.replacement <= '0;
            r_cfg.rep_len     <= '0;
            r_cfg.replace_all <= 1'b0;
            r_cfg.fold_upper  <= 1'b0;
            r_cfg.occurrence  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN:     r_cfg.pattern     <= i_cfg_data[PATTERN_MAX*8-1:0];
                CFG_PAT_LEN:     r_cfg.pat_len     <= i_cfg_data[3:0];
                CFG_REPLACEMENT: r_cfg.replacement <= i_cfg_data[REPLACE_MAX*8-1:0];
                CFG_REP_LEN:     r_cfg.rep_len     <= i_cfg_data[3:0];
                CFG_REPLACE_ALL: r_cfg.replace_all <= i_cfg_data[0];
                CFG_FOLD_UPPER:  r_cfg.fold_upper  <= i_cfg_data[0];
                CFG_OCCURRENCE:  r_cfg.occurrence  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    ssr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (front_push),
        .o_cmd    (front_cmd)
    );

    ssr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    ssr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rep_bytes (r_cfg.replacement),
        .i_q_valid   (q_valid),
        .i_q_data    (q_head),
        .o_q_pop     (q_pop),
        .o_out       (o_out)
    );

endmodule

[sim/testbench.sv]
// Testbench for stream_substring_replace: directed texts, then random texts under
// changing idle patterns, checked byte by byte against a line-by-line predictor.
// Depends on ssr_pkg, ssr_in_if, ssr_out_if and the block itself.
`timescale 1ns / 1ps

module testbench;
    import ssr_pkg::*;

    localparam int SETTLE_CYCLES  = 100;
    localparam int QUIET_LIMIT    = 4000;
    localparam int MAX_PRINTED    = 30;
    localparam int RANDOM_PER_RUN = 70;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_done;
    } t_text_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssr_in_if  in_ch();
    ssr_out_if out_ch();

    stream_substring_replace dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state: register copy plus the line being rewritten.
    t_cfg         cfg_m;
    logic [7:0]   held_bytes [PATTERN_MAX];
    int unsigned  held_n;
    int unsigned  occ_seen;
    bit           line_done;
    bit           line_active;
    bit           sent_line_before;

    t_text_result pending_text_q[$];
    int unsigned  mismatch_count;
    int unsigned  quiet_cycles;
    int unsigned  send_idle_pct;
    int unsigned  recv_stall_pct;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [7:0] fold_letter(input logic [7:0] c);
        if (cfg_m.fold_upper && c >= UPPER_A && c <= UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic void shift_window(input int unsigned k);
        if (k >= held_n) begin
            held_n = 0;
        end else begin
            for (int i = 0; i < held_n - k; i++) begin
                held_bytes[i] = held_bytes[i + k];
            end
            held_n = held_n - k;
        end
    endfunction

    function automatic void predict_substitution(input logic [7:0] b, input logic eot);
        t_text_result run_q[$];
        t_text_result r;
        int unsigned  plen;
        int unsigned  rlen;
        bit           hit;
        bit           replaced;
        plen = (cfg_m.pat_len == 0) ? 1 :
               ((cfg_m.pat_len > PATTERN_MAX) ? PATTERN_MAX : cfg_m.pat_len);
        rlen = (cfg_m.rep_len > REPLACE_MAX) ? REPLACE_MAX : cfg_m.rep_len;
        r = '0;
        r.byte_valid = 1'b1;
        if (b != NEWLINE_BYTE) begin
            if (!line_active) begin
                if (sent_line_before) begin
                    r.out_byte = NEWLINE_BYTE;
                    run_q.push_back(r);
                end
                line_active = 1'b1;
                sent_line_before = 1'b1;
            end
            if (held_n < PATTERN_MAX) begin
                held_bytes[held_n] = b;
                held_n++;
            end
            // At most one decision per byte: replace at the head or copy one byte.
            if (held_n >= plen) begin
                hit = !line_done;
                replaced = 1'b0;
                for (int k = 0; k < plen; k++) begin
                    if (fold_letter(held_bytes[k]) != fold_letter(cfg_m.pattern[k])) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    if (occ_seen < 15) occ_seen++;
                    if (cfg_m.occurrence == 0 || occ_seen == cfg_m.occurrence ||
                        cfg_m.replace_all) begin
                        for (int k = 0; k < rlen; k++) begin
                            r.out_byte = cfg_m.replacement[k];
                            run_q.push_back(r);
                        end
                        shift_window(plen);
                        if (!cfg_m.replace_all && cfg_m.occurrence == 0) line_done = 1'b1;
                        if (cfg_m.occurrence != 0 && occ_seen == cfg_m.occurrence) begin
                            line_done = 1'b1;
                        end
                        replaced = 1'b1;
                    end
                end
                if (!replaced) begin
                    r.out_byte = held_bytes[0];
                    run_q.push_back(r);
                    shift_window(1);
                end
            end
        end
        if (b == NEWLINE_BYTE || eot) begin
            if (line_active) begin
                for (int k = 0; k < held_n; k++) begin
                    r.out_byte = held_bytes[k];
                    run_q.push_back(r);
                end
            end
            held_n = 0;
            occ_seen = 0;
            line_done = 1'b0;
            line_active = 1'b0;
        end
        if (eot) begin
            sent_line_before = 1'b0;
            if (run_q.size() == 0) begin
                r = '0;
                run_q.push_back(r);
            end
        end
        if (run_q.size() != 0) begin
            run_q[run_q.size() - 1].run_last = 1'b1;
            run_q[run_q.size() - 1].text_done = eot;
        end
        foreach (run_q[i]) pending_text_q.push_back(run_q[i]);
    endfunction

    task automatic report(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Requests are predicted where they are accepted, before the output of the
    // same edge is checked; the watchdog shares the edge.
    always @(posedge i_clk) begin
        t_text_result got;
        t_text_result want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_substitution(in_ch.in_byte, in_ch.end_of_text);
            end
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.out_byte, out_ch.byte_valid, out_ch.run_last, out_ch.text_done};
                if (pending_text_q.size() == 0) begin
                    report($sformatf("unexpected result byte %h valid %b last %b done %b",
                                     got.out_byte, got.byte_valid, got.run_last,
                                     got.text_done));
                end else begin
                    want = pending_text_q.pop_front();
                    if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                        got.run_last !== want.run_last || got.text_done !== want.text_done) begin
                        report($sformatf("got byte %h valid %b last %b done %b, want %h %b %b %b",
                                         got.out_byte, got.byte_valid, got.run_last,
                                         got.text_done, want.out_byte, want.byte_valid,
                                         want.run_last, want.text_done));
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("ERROR: no progress for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, pending_text_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Returns at the accepting edge; the caller's next step lowers or reloads valid.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.in_byte     <= b;
        in_ch.end_of_text <= eot;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s, input bit close_text);
        for (int k = 0; k < s.len(); k++) begin
            send_byte(s[k], close_text && k == s.len() - 1);
        end
    endtask

    // Holds the sender back until every expected result is out, then lets the
    // back end finish any request that yields nothing.
    task automatic settle_block();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_text_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            CFG_PATTERN:     cfg_m.pattern     = value;
            CFG_PAT_LEN:     cfg_m.pat_len     = value[3:0];
            CFG_REPLACEMENT: cfg_m.replacement = value;
            CFG_REP_LEN:     cfg_m.rep_len     = value[3:0];
            CFG_REPLACE_ALL: cfg_m.replace_all = value[0];
            CFG_FOLD_UPPER:  cfg_m.fold_upper  = value[0];
            CFG_OCCURRENCE:  cfg_m.occurrence  = value[3:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] pack_text(input string s);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < s.len() && k < 8; k++) v[8*k +: 8] = s[k];
        return v;
    endfunction

    task automatic configure(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] rep, input logic [3:0] rlen,
                             input bit all, input bit icase, input logic [3:0] occ);
        set_reg(CFG_PATTERN, pat);
        set_reg(CFG_PAT_LEN, 64'(plen));
        set_reg(CFG_REPLACEMENT, rep);
        set_reg(CFG_REP_LEN, 64'(rlen));
        set_reg(CFG_REPLACE_ALL, 64'(all));
        set_reg(CFG_FOLD_UPPER, 64'(icase));
        set_reg(CFG_OCCURRENCE, 64'(occ));
    endtask

    // Reset pattern is a single zero byte: the first zero of a line is deleted.
    // A text that closes on a bare newline yields only the end marker.
    task automatic test_zero_byte_and_end_marker();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(NEWLINE_BYTE, 1'b1);
        settle_block();
    endtask

    // First occurrence only, case folded, with an empty line dropped and the
    // held tail of each line flushed at its end.
    task automatic test_first_match_folded();
        configure(pack_text("aa"), 4'd2, pack_text("XYZ"), 4'd3, 1'b0, 1'b1, 4'd0);
        send_text("aAa\n\naa", 1'b1);
        settle_block();
    endtask

    // Global with a count replaces the first N; oversized replacement length
    // is cut to the maximum.
    task automatic test_first_n_global();
        configure(pack_text("a"), 4'd1, pack_text("12345678"), 4'd15, 1'b1, 1'b0, 4'd2);
        send_text("aaa", 1'b1);
        settle_block();
    endtask

    // Only the second occurrence is deleted; a zero pattern length acts as one.
    task automatic test_nth_deletion();
        configure(pack_text("a"), 4'd0, '1, 4'd0, 1'b0, 1'b0, 4'd2);
        send_text("aaa", 1'b1);
        settle_block();
    endtask

    // Every occurrence, with a skip over each replaced pattern.
    task automatic test_global_overlap();
        configure(pack_text("aa"), 4'd2, pack_text("Q"), 4'd1, 1'b1, 1'b0, 4'd0);
        send_text("aaaa", 1'b1);
        settle_block();
    endtask

    // The pattern changes while a line is open and bytes are still held.
    task automatic test_midline_reconfig();
        configure(pack_text("bc"), 4'd15, pack_text("#"), 4'd1, 1'b1, 1'b0, 4'd10);
        send_text("ab", 1'b0);
        settle_block();
        set_reg(CFG_PATTERN, pack_text("b"));
        set_reg(CFG_PAT_LEN, 64'd1);
        send_text("c", 1'b1);
        settle_block();
    endtask

    task automatic randomize_config();
        logic [63:0] pat;
        logic [63:0] rep;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        logic [3:0]  occ;
        int unsigned roll;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(3))
                0: pat[8*k +: 8] = "a";
                1: pat[8*k +: 8] = "b";
                2: pat[8*k +: 8] = "A";
                default: pat[8*k +: 8] = 8'($urandom_range(255));
            endcase
        end
        rep = {$urandom, $urandom};
        roll = $urandom_range(19);
        if (roll == 0) begin
            pat = '1;
            rep = '0;
        end else if (roll == 1) begin
            pat = {$urandom, $urandom};
            rep = '1;
        end
        roll = $urandom_range(19);
        if (roll < 14)       plen = 4'($urandom_range(1, 4));
        else if (roll < 16)  plen = 4'd8;
        else if (roll == 16) plen = 4'd0;
        else if (roll == 17) plen = 4'd15;
        else                 plen = 4'($urandom_range(5, 15));
        rlen = ($urandom_range(9) < 8) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
        occ  = ($urandom_range(9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        configure(pat, plen, rep, rlen, 1'($urandom_range(1)), 1'($urandom_range(1)), occ);
    endtask

    // Mostly lines seeded with whole or partial copies of the pattern, with
    // noise bytes, empty lines and stray newlines mixed in.
    task automatic send_random_text(output int unsigned n);
        logic [7:0]  text_q[$];
        logic [7:0]  c;
        int unsigned plen;
        int unsigned len;
        int unsigned take;
        int unsigned roll;
        plen = (cfg_m.pat_len == 0) ? 1 :
               ((cfg_m.pat_len > PATTERN_MAX) ? PATTERN_MAX : cfg_m.pat_len);
        if ($urandom_range(9) == 0) text_q.push_back(NEWLINE_BYTE);
        for (int l = $urandom_range(1, 4); l > 0; l--) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                roll = $urandom_range(99);
                if (roll < 35) begin
                    take = ($urandom_range(3) == 0) ? $urandom_range(1, plen) : plen;
                    for (int k = 0; k < take; k++) begin
                        c = cfg_m.pattern[k];
                        if ($urandom_range(1)) begin
                            if (c >= UPPER_A && c <= UPPER_Z) begin
                                c = c + CASE_OFFSET;
                            end else if (c >= UPPER_A + CASE_OFFSET &&
                                         c <= UPPER_Z + CASE_OFFSET) begin
                                c = c - CASE_OFFSET;
                            end
                        end
                        text_q.push_back(c);
                    end
                end else if (roll < 70) begin
                    text_q.push_back(cfg_m.pattern[$urandom_range(plen - 1)]);
                end else if (roll < 96) begin
                    text_q.push_back(8'($urandom_range(1, 255)));
                end else begin
                    text_q.push_back(8'h00);
                end
            end
            if (l > 1 || $urandom_range(7) == 0) text_q.push_back(NEWLINE_BYTE);
            if ($urandom_range(9) == 0) text_q.push_back(NEWLINE_BYTE);
        end
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
        n = text_q.size();
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct);
        int unsigned sent;
        int unsigned n;
        sent = 0;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < RANDOM_PER_RUN) begin
            randomize_config();
            send_random_text(n);
            sent += n;
            settle_block();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_PATTERN;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.in_byte     = 8'h00;
        in_ch.end_of_text = 1'b0;
        out_ch.ready      = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        mismatch_count    = 0;
        quiet_cycles      = 0;
        cfg_m             = '0;
        cfg_m.pat_len     = 4'd1;
        held_n            = 0;
        occ_seen          = 0;
        line_done         = 1'b0;
        line_active       = 1'b0;
        sent_line_before  = 1'b0;
        foreach (held_bytes[i]) held_bytes[i] = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_byte_and_end_marker();
        test_first_match_folded();
        test_first_n_global();
        test_nth_deletion();
        test_global_overlap();
        test_midline_reconfig();
        test_random_traffic(0, 0);
        test_random_traffic(62, 0);
        test_random_traffic(0, 62);
        test_random_traffic(10, 10);

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/ssr_pkg.sv
rtl/ssr_in_if.sv
rtl/ssr_out_if.sv
rtl/ssr_front.sv
rtl/ssr_cmd_fifo.sv
rtl/ssr_back.sv
rtl/stream_substring_replace.sv
sim/testbench.sv
